@@ rtl/assert_macros.svh @@
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while reset is asserted.
`define QS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define QS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/qsmc_pkg.sv @@
// ----------------------------------------------------------------------------
// qsmc_pkg
// Shared types, codes and tables of the quadrature speed motor controller.
// ----------------------------------------------------------------------------
package qsmc_pkg;

  localparam logic OP_ENC  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] REG_PROP_GAIN   = 2'd0;
  localparam logic [1:0] REG_FEED_GAIN   = 2'd1;
  localparam logic [1:0] REG_MIN_FORCE   = 2'd2;
  localparam logic [1:0] REG_CAMERA_MODE = 2'd3;

  localparam int CFG_ADDR_BITS = 4;

  typedef struct packed {
    logic              op;
    logic              enc_a;
    logic              enc_b;
    logic [31:0]       now_us;
    logic signed [23:0] target_speed;
  } in_item_t;

  typedef struct packed {
    logic              drive_fwd;
    logic              drive_rev;
    logic [7:0]        duty;
    logic signed [23:0] speed_est;
  } out_item_t;

  typedef struct packed {
    logic [15:0] prop_gain;
    logic [15:0] feed_gain;
    logic [7:0]  min_force;
    logic        camera_mode;
  } cfg_t;

  // Quadrature step for {previous AB, current AB}.
  function automatic logic signed [1:0] step_lut(input logic [3:0] idx);
    logic signed [1:0] s;
    unique case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: s = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
      default: s = 2'sd0;
    endcase
    return s;
  endfunction

endpackage

@@ rtl/qsmc_front.sv @@
// ----------------------------------------------------------------------------
// qsmc_front
// Accepts items, decodes encoder samples into position, queues control ticks.
// ----------------------------------------------------------------------------
module qsmc_front #(
  parameter int POSITION_BITS = 32,
  parameter int ENTRY_BITS    = 88
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  output logic                     in_full,
  input  qsmc_pkg::in_item_t       in_data,
  output logic                     q_push,
  output logic [ENTRY_BITS-1:0]    q_data,
  input  logic                     q_full
);
  import qsmc_pkg::*;

  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [1:0]               last_ab_r;
  logic                     accept;
  logic signed [1:0]        step;

  assign in_full = q_full;
  assign accept  = in_push & ~q_full;
  assign step    = step_lut({last_ab_r, in_data.enc_a, in_data.enc_b});
  assign pos_nxt = pos_r + {{(POSITION_BITS-2){step[1]}}, step};

  assign q_push = accept & (in_data.op == OP_TICK);
  assign q_data = {in_data.now_us, in_data.target_speed, pos_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      last_ab_r <= '0;
    end else if (accept && in_data.op == OP_ENC) begin
      pos_r     <= pos_nxt;
      last_ab_r <= {in_data.enc_a, in_data.enc_b};
    end
  end

endmodule

@@ rtl/qsmc_fifo.sv @@
// ----------------------------------------------------------------------------
// qsmc_fifo
// Two-entry queue of control ticks between the front and the back.
// ----------------------------------------------------------------------------
module qsmc_fifo #(
  parameter int WIDTH = 88
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  logic [WIDTH-1:0] mem_r [2];
  logic             wptr_r, rptr_r;
  logic [1:0]       cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop)  rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ rtl/qsmc_back.sv @@
// ----------------------------------------------------------------------------
// qsmc_back
// Runs one control tick: speed estimate with a bit-serial divider, EMA,
// feedforward plus P, shaping; holds the result until it is taken.
// ----------------------------------------------------------------------------
module qsmc_back #(
  parameter int POSITION_BITS   = 32,
  parameter int MIN_INTERVAL_US = 5000,
  parameter int ENTRY_BITS      = 88
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  qsmc_pkg::cfg_t         cfg,
  input  logic                   q_empty,
  input  logic [ENTRY_BITS-1:0]  q_data,
  output logic                   q_pop,
  input  logic                   out_pop,
  output logic                   out_empty,
  output qsmc_pkg::out_item_t    out_data
);
  import qsmc_pkg::*;

  localparam int PB  = POSITION_BITS;
  localparam int MW  = (PB > 32) ? PB : 32;
  localparam int NW  = 59;
  localparam int CW  = $clog2(NW);
  localparam logic [27:0] SPEED_SCALE = 28'd256000000;
  localparam logic signed [42:0] ONE_Q20 = 43'sd1 <<< 20;
  localparam logic signed [42:0] LIM_Q20 = 43'sd255 <<< 20;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_DIV, S_SAT, S_EMA, S_PRODF, S_PRODP, S_DONE
  } state_t;

  state_t             state_r;
  logic [31:0]        now_r, prev_time_r, dt_r;
  logic signed [23:0] target_r, filt_r, raw_r;
  logic [PB-1:0]      pos_r, prev_pos_r;
  logic [NW-1:0]      num_r;
  logic [31:0]        rem_r;
  logic [CW-1:0]      cnt_r;
  logic               neg_r;
  logic signed [40:0] prod_f_r;
  logic signed [41:0] prod_p_r;
  logic               out_valid_r;
  out_item_t          out_r;

  // speed path
  logic [31:0]        dt_w;
  logic [PB-1:0]      d_w, mag_w;
  logic [MW-1:0]      mag_ext;
  logic               big_w;
  logic [32:0]        rem_sh, rem_sub;
  logic signed [32:0] ema_w;
  logic signed [23:0] raw_w;

  // control path
  logic signed [24:0] diff_w;
  logic signed [42:0] u_w, u1_w, u2_w, mf_w, magu_w;
  logic [7:0]         pwm_w, pwm_s;
  logic               small_w, fwd_w, rev_w;

  assign dt_w    = now_r - prev_time_r;
  assign d_w     = pos_r - prev_pos_r;
  assign mag_w   = d_w[PB-1] ? (~d_w + 1'b1) : d_w;
  assign mag_ext = MW'(mag_w);
  assign big_w   = |mag_ext[MW-1:31];

  assign rem_sh  = {rem_r, num_r[NW-1]};
  assign rem_sub = rem_sh - {1'b0, dt_r};

  always_comb begin
    if (neg_r) begin
      raw_w = (num_r > NW'(24'd8388608)) ? -24'sd8388608 : 24'(-num_r[23:0]);
    end else begin
      raw_w = (num_r > NW'(24'd8388607)) ? 24'sd8388607 : $signed(num_r[23:0]);
    end
  end

  assign ema_w = 33'(raw_r) * 33'sd51 + 33'(filt_r) * 33'sd205 + 33'sd128;

  assign diff_w  = 25'(target_r) - 25'(filt_r);
  assign small_w = (target_r > -24'sd512) && (target_r < 24'sd512);
  assign u_w     = 43'(prod_f_r) + 43'(prod_p_r);
  assign mf_w    = $signed({15'd0, cfg.min_force, 20'd0});

  always_comb begin
    u1_w = u_w;
    if (u_w > 0 && u_w < mf_w) u1_w = mf_w;
    if (u_w < 0 && u_w > -mf_w) u1_w = -mf_w;
    u2_w = u1_w;
    if (u1_w > LIM_Q20) u2_w = LIM_Q20;
    if (u1_w < -LIM_Q20) u2_w = -LIM_Q20;
    magu_w = (u2_w < 0) ? -u2_w : u2_w;
    pwm_w  = magu_w[27:20];
    pwm_s  = pwm_w;
    if (cfg.camera_mode) begin
      if (pwm_w != 8'd0 && pwm_w < 8'd120) pwm_s = 8'd120;
    end else begin
      if (pwm_w != 8'd0 && pwm_w < 8'd35) pwm_s = 8'd0;
    end
    fwd_w = (u2_w > ONE_Q20);
    rev_w = !fwd_w && (u2_w < -ONE_Q20);
  end

  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      prev_time_r <= '0;
      prev_pos_r  <= '0;
      filt_r      <= '0;
    end else begin
      // load a new beat when the slot frees, else drop the taken one
      if (state_r == S_DONE && (!out_valid_r || out_pop)) begin
        out_valid_r <= 1'b1;
      end else if (out_pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            now_r    <= q_data[ENTRY_BITS-1 -: 32];
            target_r <= $signed(q_data[PB+23:PB]);
            pos_r    <= q_data[PB-1:0];
            state_r  <= S_CHECK;
          end
        end
        S_CHECK: begin
          dt_r  <= dt_w;
          neg_r <= d_w[PB-1];
          rem_r <= '0;
          cnt_r <= '0;
          if (dt_w < 32'(MIN_INTERVAL_US)) begin
            state_r <= S_PRODF;
          end else if (big_w) begin
            raw_r   <= d_w[PB-1] ? -24'sd8388608 : 24'sd8388607;
            state_r <= S_EMA;
          end else begin
            num_r   <= NW'(mag_ext[30:0]) * NW'(SPEED_SCALE);
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          // one quotient bit per cycle, restoring
          if (!rem_sub[32]) begin
            rem_r <= rem_sub[31:0];
            num_r <= {num_r[NW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh[31:0];
            num_r <= {num_r[NW-2:0], 1'b0};
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CW'(NW-1)) state_r <= S_SAT;
        end
        S_SAT: begin
          raw_r   <= raw_w;
          state_r <= S_EMA;
        end
        S_EMA: begin
          filt_r      <= ema_w[31:8];
          prev_pos_r  <= pos_r;
          prev_time_r <= now_r;
          state_r     <= S_PRODF;
        end
        S_PRODF: begin
          prod_f_r <= 41'(target_r) * 41'($signed({1'b0, cfg.feed_gain}));
          state_r  <= S_PRODP;
        end
        S_PRODP: begin
          prod_p_r <= 42'(diff_w) * 42'($signed({1'b0, cfg.prop_gain}));
          state_r  <= S_DONE;
        end
        S_DONE: begin
          // hold until the output slot is free
          if (!out_valid_r || out_pop) begin
            if (small_w) begin
              filt_r <= '0;
              out_r  <= '0;
            end else begin
              out_r.drive_fwd <= fwd_w;
              out_r.drive_rev <= rev_w;
              out_r.duty      <= (fwd_w || rev_w) ? pwm_s : 8'd0;
              out_r.speed_est <= filt_r;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/quadrature_speed_motor_controller.sv @@
// ----------------------------------------------------------------------------
// quadrature_speed_motor_controller
// Quadrature decoder with a feedforward plus P speed loop for one DC motor.
// ----------------------------------------------------------------------------
//  channel  ports           beat
//  input    in_push/in_full one encoder sample or control tick
//  result   out_pop/out_empty one bridge command per control tick
//  config   cfg_p*          32-bit register write or read
//
// Encoder samples yield no result. A control tick is checked first: a short
// interval skips to the feedforward and P products, a saturated raw speed
// skips to the EMA, else the 59-step bit-serial divider of the back end
// estimates the speed first. Reset is synchronous and clears position,
// speed state and both queues. A full result slot stalls the back end; a
// two-entry tick queue lets the front keep decoding.
module quadrature_speed_motor_controller #(
  parameter int POSITION_BITS   = 32,
  parameter int MIN_INTERVAL_US = 5000
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  qsmc_pkg::in_item_t                 in_data,
  input  logic                               out_pop,
  output logic                               out_empty,
  output qsmc_pkg::out_item_t                out_data,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [qsmc_pkg::CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [31:0]                        cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);
  import qsmc_pkg::*;

  localparam int ENTRY_BITS = 56 + POSITION_BITS;

  cfg_t                  cfg_r;
  logic                  q_push, q_pop, q_full, q_empty;
  logic [ENTRY_BITS-1:0] q_wdata, q_rdata;
  logic [1:0]            reg_idx;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain   <= 16'd737;
      cfg_r.feed_gain   <= 16'd3277;
      cfg_r.min_force   <= 8'd45;
      cfg_r.camera_mode <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (reg_idx)
        REG_PROP_GAIN:   cfg_r.prop_gain   <= cfg_pwdata[15:0];
        REG_FEED_GAIN:   cfg_r.feed_gain   <= cfg_pwdata[15:0];
        REG_MIN_FORCE:   cfg_r.min_force   <= cfg_pwdata[7:0];
        REG_CAMERA_MODE: cfg_r.camera_mode <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PROP_GAIN:   cfg_prdata = {16'd0, cfg_r.prop_gain};
      REG_FEED_GAIN:   cfg_prdata = {16'd0, cfg_r.feed_gain};
      REG_MIN_FORCE:   cfg_prdata = {24'd0, cfg_r.min_force};
      REG_CAMERA_MODE: cfg_prdata = {31'd0, cfg_r.camera_mode};
      default:         cfg_prdata = '0;
    endcase
  end

  qsmc_front #(
    .POSITION_BITS(POSITION_BITS),
    .ENTRY_BITS   (ENTRY_BITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_data(in_data),
    .q_push (q_push),
    .q_data (q_wdata),
    .q_full (q_full)
  );

  qsmc_fifo #(
    .WIDTH(ENTRY_BITS)
  ) u_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .full (q_full),
    .pop  (q_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  qsmc_back #(
    .POSITION_BITS  (POSITION_BITS),
    .MIN_INTERVAL_US(MIN_INTERVAL_US),
    .ENTRY_BITS     (ENTRY_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_empty  (q_empty),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .out_pop  (out_pop),
    .out_empty(out_empty),
    .out_data (out_data)
  );

endmodule

@@ rtl/qsmc_chk.sv @@
// ----------------------------------------------------------------------------
// qsmc_chk
// Port-level checks on the result channel of the controller.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qsmc_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                out_pop,
  input logic                out_empty,
  input qsmc_pkg::out_item_t out_data
);
  import qsmc_pkg::*;

  logic both_dir, no_dir, stall;

  assign both_dir = out_data.drive_fwd && out_data.drive_rev;
  assign no_dir   = !out_data.drive_fwd && !out_data.drive_rev;
  assign stall    = !out_empty && !out_pop;

  `QS_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> out_empty, "result pending after reset")
  `QS_ASSERT(a_one_dir, clk, rst_n, !out_empty |-> !both_dir, "both bridge inputs high")
  `QS_ASSERT(a_dead_duty, clk, rst_n, (!out_empty && no_dir) |-> out_data.duty == 8'd0, "idle duty")
  `QS_ASSERT(a_hold_beat, clk, rst_n, stall |=> (!out_empty && $stable(out_data)), "beat changed")

endmodule

bind quadrature_speed_motor_controller qsmc_chk u_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_pop  (out_pop),
  .out_empty(out_empty),
  .out_data (out_data)
);
